// File: rtl/core/dqku_pkg.sv
// Package for the double-ended store with key update.
// Sizes, action and status codes and sequencer states; no dependencies.
package dqku_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = SLOT_W + 1;

    typedef enum logic [2:0] {
        ACT_PUSH_HEAD = 3'd0,
        ACT_POP_HEAD  = 3'd1,
        ACT_POP_TAIL  = 3'd2,
        ACT_LIST_HEAD = 3'd3,
        ACT_LIST_TAIL = 3'd4,
        ACT_MODIFY    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_EVAL  = 2'd2,
        S_SEND  = 2'd3
    } state_t;

endpackage

// File: rtl/core/dqku_if.sv
// Handshake channels of the double-ended store: command words in, result words out.
// Depends on dqku_pkg for field widths.
interface dqku_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          action;
    logic signed [dqku_pkg::DATA_W-1:0]  item_code;
    logic [dqku_pkg::DATA_W-1:0]         item_name;
    logic signed [dqku_pkg::DATA_W-1:0]  new_code;
    logic [dqku_pkg::DATA_W-1:0]         new_name;

    modport source (output valid, action, item_code, item_name, new_code, new_name,
                    input ready);
    modport sink   (input valid, action, item_code, item_name, new_code, new_name,
                    output ready);
endinterface

interface dqku_res_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [dqku_pkg::DATA_W-1:0]  out_code;
    logic [dqku_pkg::DATA_W-1:0]         out_name;
    logic                                last;

    modport source (output valid, status, out_code, out_name, last, input ready);
    modport sink   (input valid, status, out_code, out_name, last, output ready);
endinterface

// File: rtl/core/deque_with_key_update.sv
// Top level of the bounded double-ended store of (code, name tag) entries.
// Depends on dqku_pkg and the channel interfaces in dqku_if.sv.
//
// Usage
//   cmd : command words (action, item_code, item_name, new_code, new_name).
//         Taken at an edge with cmd.valid and cmd.ready high. ready is high
//         only while the sequencer is idle: one command is worked at a time.
//   res : result words (status, out_code, out_name, last). last marks the
//         final word of a command. Unused action codes give no word at all.
// Sequencing
//   push, push when full, any action on an empty store: result word valid
//   the cycle after acceptance.
//   pop head / pop tail: the entry is fetched, evaluated, then sent.
//   list: fetch, evaluate and send for each listed entry in turn.
//   modify: fetch and evaluate for each compared entry, then the result word.
//   The sequence is set by the single registered read port of the entry
//   store; every entry visited passes through a fetch and an evaluate state.
// Reset clears head pointer, fill count and sequencer; the store itself is
// not cleared, only occupied slots are ever read.
// A stalled receiver holds the result register; the walk resumes when the
// word is taken and no command is taken meanwhile.
module deque_with_key_update (
    input  logic          clk,
    input  logic          rst_n,
    dqku_cmd_if.sink      cmd,
    dqku_res_if.source    res
);

    localparam logic [dqku_pkg::SUM_W-1:0]  DEPTH_S = dqku_pkg::SUM_W'(dqku_pkg::DEPTH);
    localparam logic [dqku_pkg::CNT_W-1:0]  DEPTH_C = dqku_pkg::CNT_W'(dqku_pkg::DEPTH);
    localparam logic [dqku_pkg::SLOT_W-1:0] SLOT_MAX = dqku_pkg::SLOT_W'(dqku_pkg::DEPTH - 1);

    // entry store, one write and one registered read port
    logic [dqku_pkg::DATA_W-1:0] code_mem [dqku_pkg::DEPTH];
    logic [dqku_pkg::DATA_W-1:0] name_mem [dqku_pkg::DEPTH];

    dqku_pkg::state_t            state_reg, state_next;
    logic [2:0]                  act_reg, act_next;
    logic [dqku_pkg::DATA_W-1:0] icode_reg, icode_next;
    logic [dqku_pkg::DATA_W-1:0] ncode_reg, ncode_next;
    logic [dqku_pkg::DATA_W-1:0] nname_reg, nname_next;
    logic [dqku_pkg::SLOT_W-1:0] head_reg, head_next;
    logic [dqku_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [dqku_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic [dqku_pkg::SLOT_W-1:0] addr_reg;
    logic [dqku_pkg::DATA_W-1:0] rd_code_reg, rd_name_reg;
    logic [1:0]                  ostat_reg, ostat_next;
    logic [dqku_pkg::DATA_W-1:0] ocode_reg, ocode_next;
    logic [dqku_pkg::DATA_W-1:0] oname_reg, oname_next;
    logic                        olast_reg, olast_next;

    logic                        rd_en;
    logic                        mem_we;
    logic [dqku_pkg::SLOT_W-1:0] mem_waddr;
    logic [dqku_pkg::DATA_W-1:0] mem_wcode, mem_wname;

    logic [dqku_pkg::CNT_W-1:0]  offset;
    logic [dqku_pkg::SUM_W-1:0]  slot_sum;
    logic [dqku_pkg::SLOT_W-1:0] slot;
    logic [dqku_pkg::SLOT_W-1:0] head_dec, head_inc;
    logic                        walk_last;
    logic                        cmd_take;

    // ready straight from the state register, no path back from valid
    assign cmd.ready = (state_reg == dqku_pkg::S_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;

    // shared address unit: head + offset, folded once modulo DEPTH
    always_comb
    begin
        unique case (act_reg)
            dqku_pkg::ACT_POP_HEAD:  offset = '0;
            dqku_pkg::ACT_POP_TAIL:  offset = count_reg - dqku_pkg::CNT_W'(1);
            dqku_pkg::ACT_LIST_TAIL: offset = count_reg - dqku_pkg::CNT_W'(1)
                                              - dqku_pkg::CNT_W'(idx_reg);
            default:                 offset = dqku_pkg::CNT_W'(idx_reg);
        endcase
        slot_sum = dqku_pkg::SUM_W'(head_reg) + dqku_pkg::SUM_W'(offset[dqku_pkg::SLOT_W-1:0]);
        if (slot_sum >= DEPTH_S)
        begin
            slot_sum = slot_sum - DEPTH_S;
        end
        slot = slot_sum[dqku_pkg::SLOT_W-1:0];
    end

    assign head_dec  = (head_reg == '0) ? SLOT_MAX : head_reg - dqku_pkg::SLOT_W'(1);
    assign head_inc  = (head_reg == SLOT_MAX) ? '0 : head_reg + dqku_pkg::SLOT_W'(1);
    assign walk_last = (dqku_pkg::CNT_W'(idx_reg) + dqku_pkg::CNT_W'(1)) == count_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        icode_next = icode_reg;
        ncode_next = ncode_reg;
        nname_next = nname_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ostat_next = ostat_reg;
        ocode_next = ocode_reg;
        oname_next = oname_reg;
        olast_next = olast_reg;
        rd_en      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = head_dec;
        mem_wcode  = cmd.item_code;
        mem_wname  = cmd.item_name;

        unique case (state_reg)
            dqku_pkg::S_IDLE:
            begin
                if (cmd_take)
                begin
                    act_next   = cmd.action;
                    icode_next = cmd.item_code;
                    ncode_next = cmd.new_code;
                    nname_next = cmd.new_name;
                    idx_next   = '0;
                    ocode_next = '0;
                    oname_next = '0;
                    olast_next = 1'b1;
                    if (cmd.action > dqku_pkg::ACT_MODIFY)
                    begin
                        state_next = dqku_pkg::S_IDLE;   // unused code, dropped
                    end
                    else if (cmd.action == dqku_pkg::ACT_PUSH_HEAD)
                    begin
                        state_next = dqku_pkg::S_SEND;
                        if (count_reg >= DEPTH_C)
                        begin
                            ostat_next = dqku_pkg::ST_FULL;
                        end
                        else
                        begin
                            ostat_next = dqku_pkg::ST_OK;
                            mem_we     = 1'b1;
                            head_next  = head_dec;
                            count_next = count_reg + dqku_pkg::CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        ostat_next = dqku_pkg::ST_EMPTY;
                        state_next = dqku_pkg::S_SEND;
                    end
                    else
                    begin
                        state_next = dqku_pkg::S_FETCH;
                    end
                end
            end
            dqku_pkg::S_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = dqku_pkg::S_EVAL;
            end
            dqku_pkg::S_EVAL:
            begin
                ostat_next = dqku_pkg::ST_OK;
                ocode_next = rd_code_reg;
                oname_next = rd_name_reg;
                olast_next = 1'b1;
                state_next = dqku_pkg::S_SEND;
                priority if (act_reg == dqku_pkg::ACT_POP_HEAD)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - dqku_pkg::CNT_W'(1);
                end
                else if (act_reg == dqku_pkg::ACT_POP_TAIL)
                begin
                    count_next = count_reg - dqku_pkg::CNT_W'(1);
                end
                else if (act_reg == dqku_pkg::ACT_MODIFY)
                begin
                    if (rd_code_reg == icode_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_reg;
                        mem_wcode = ncode_reg;
                        mem_wname = nname_reg;
                    end
                    else if (walk_last)
                    begin
                        ostat_next = dqku_pkg::ST_NOT_FOUND;
                        ocode_next = '0;
                        oname_next = '0;
                    end
                    else
                    begin
                        idx_next   = idx_reg + dqku_pkg::SLOT_W'(1);
                        state_next = dqku_pkg::S_FETCH;
                    end
                end
                else
                begin
                    olast_next = walk_last;
                end
            end
            dqku_pkg::S_SEND:
            begin
                if (res.ready)
                begin
                    if (olast_reg)
                    begin
                        state_next = dqku_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + dqku_pkg::SLOT_W'(1);
                        state_next = dqku_pkg::S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = dqku_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqku_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        icode_reg <= icode_next;
        ncode_reg <= ncode_next;
        nname_reg <= nname_next;
        ostat_reg <= ostat_next;
        ocode_reg <= ocode_next;
        oname_reg <= oname_next;
        olast_reg <= olast_next;
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            code_mem[mem_waddr] <= mem_wcode;
            name_mem[mem_waddr] <= mem_wname;
        end
        if (rd_en)
        begin
            addr_reg    <= slot;
            rd_code_reg <= code_mem[slot];
            rd_name_reg <= name_mem[slot];
        end
    end

    assign res.valid    = (state_reg == dqku_pkg::S_SEND);
    assign res.status   = ostat_reg;
    assign res.out_code = ocode_reg;
    assign res.out_name = oname_reg;
    assign res.last     = olast_reg;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !cmd.ready)
        else $error("command taken while a result word is pending");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqku_pkg::S_FETCH) |-> (count_reg != '0))
        else $error("store walk started on an empty store");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= DEPTH_C) && (head_reg <= SLOT_MAX))
        else $error("fill count or head pointer out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && (cmd.action == dqku_pkg::ACT_PUSH_HEAD) && (count_reg < DEPTH_C))
        |=> (count_reg == $past(count_reg) + dqku_pkg::CNT_W'(1)))
        else $error("accepted push did not grow the fill count");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqku_pkg::S_FETCH) |-> (dqku_pkg::CNT_W'(idx_reg) < count_reg))
        else $error("walk index beyond stored entries");

endmodule

// File: tb/tb_deque_with_key_update.sv
// Self-checking bench for deque_with_key_update: directed then random command words.
// It holds a shadow copy of the store, which predicts every result word.
// Depends on dqku_pkg, dqku_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_deque_with_key_update;

    // Action codes 6 and 7 are not part of action_t. The block takes them and
    // must answer with nothing.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_CMDS    = 400;   // the directed part brings it to about 420
    localparam int STALL_PCT      = 24;    // per-cycle idle chance, both sides
    localparam int WATCHDOG_LIMIT = 2000;  // worst modify walks every stored entry, plus stalls
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        dqku_pkg::status_t                   status;
        logic signed [dqku_pkg::DATA_W-1:0]  code;
        logic [dqku_pkg::DATA_W-1:0]         name;
        logic                                last;
    } result_word_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_t;

    // ------------------------------------------------------------------
    // Shadow store. It predicts the result words of each accepted command
    // word and checks the words that the block returns, in order.
    // ------------------------------------------------------------------
    class deque_shadow;
        logic signed [dqku_pkg::DATA_W-1:0] codes [dqku_pkg::DEPTH];
        logic [dqku_pkg::DATA_W-1:0]        names [dqku_pkg::DEPTH];
        int unsigned                        head;
        int unsigned                        fill;
        result_word_t                       pending_words [$];

        int unsigned mismatches    = 0;
        int unsigned words_seen    = 0;
        int unsigned commands      = 0;
        int unsigned ignored       = 0;
        int unsigned full_rejects  = 0;
        int unsigned empty_hits    = 0;
        int unsigned modify_hits   = 0;
        int unsigned modify_misses = 0;
        int unsigned longest_list  = 0;

        function new();
            head = 0;
            fill = 0;
            foreach (codes[k])
            begin
                codes[k] = '0;
                names[k] = '0;
            end
        endfunction

        function int unsigned slot(int unsigned offset);
            return (head + offset) % dqku_pkg::DEPTH;
        endfunction

        function void push_word(dqku_pkg::status_t st,
                                logic signed [dqku_pkg::DATA_W-1:0] code,
                                logic [dqku_pkg::DATA_W-1:0] name, logic last);
            result_word_t w;
            w.status = st;
            w.code   = code;
            w.name   = name;
            w.last   = last;
            pending_words.push_back(w);
        endfunction

        function void note_command(logic [2:0] act,
                                   logic signed [dqku_pkg::DATA_W-1:0] icode,
                                   logic [dqku_pkg::DATA_W-1:0] iname,
                                   logic signed [dqku_pkg::DATA_W-1:0] ncode,
                                   logic [dqku_pkg::DATA_W-1:0] nname);
            int unsigned s;
            bit          found;
            commands++;
            if (act > dqku_pkg::ACT_MODIFY)
            begin
                ignored++;
                return;
            end
            if (act == dqku_pkg::ACT_PUSH_HEAD)
            begin
                if (fill == dqku_pkg::DEPTH)
                begin
                    full_rejects++;
                    push_word(dqku_pkg::ST_FULL, '0, '0, 1'b1);
                    return;
                end
                head        = slot(dqku_pkg::DEPTH - 1);
                codes[head] = icode;
                names[head] = iname;
                fill++;
                push_word(dqku_pkg::ST_OK, '0, '0, 1'b1);
                return;
            end
            if (fill == 0)
            begin
                empty_hits++;
                push_word(dqku_pkg::ST_EMPTY, '0, '0, 1'b1);
                return;
            end
            case (act)
                dqku_pkg::ACT_POP_HEAD:
                begin
                    s = head;
                    push_word(dqku_pkg::ST_OK, codes[s], names[s], 1'b1);
                    head = slot(1);
                    fill--;
                end
                dqku_pkg::ACT_POP_TAIL:
                begin
                    s = slot(fill - 1);
                    push_word(dqku_pkg::ST_OK, codes[s], names[s], 1'b1);
                    fill--;
                end
                dqku_pkg::ACT_LIST_HEAD:
                begin
                    for (int unsigned k = 0; k < fill; k++)
                        push_word(dqku_pkg::ST_OK, codes[slot(k)], names[slot(k)],
                                  k + 1 == fill);
                    if (fill > longest_list)
                        longest_list = fill;
                end
                dqku_pkg::ACT_LIST_TAIL:
                begin
                    for (int unsigned k = 0; k < fill; k++)
                    begin
                        s = slot(fill - 1 - k);
                        push_word(dqku_pkg::ST_OK, codes[s], names[s], k + 1 == fill);
                    end
                    if (fill > longest_list)
                        longest_list = fill;
                end
                dqku_pkg::ACT_MODIFY:
                begin
                    found = 1'b0;
                    for (int unsigned k = 0; k < fill && !found; k++)
                    begin
                        s = slot(k);
                        if (codes[s] == icode)
                        begin
                            push_word(dqku_pkg::ST_OK, codes[s], names[s], 1'b1);
                            codes[s] = ncode;
                            names[s] = nname;
                            found    = 1'b1;
                        end
                    end
                    if (found)
                        modify_hits++;
                    else
                    begin
                        modify_misses++;
                        push_word(dqku_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_word(logic [1:0] status,
                                 logic signed [dqku_pkg::DATA_W-1:0] code,
                                 logic [dqku_pkg::DATA_W-1:0] name, logic last);
            result_word_t want;
            words_seen++;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result word with nothing pending: %s %0d %h %h %0b",
                             $realtime, "status/code/name/last", status, code, name, last);
                return;
            end
            want = pending_words.pop_front();
            if (status !== want.status || code !== want.code ||
                name !== want.name || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t: word mismatch, expected status %0d code %h name %h last %0b",
                             $realtime, want.status, want.code, want.name, want.last);
                    $display("%0t:                  got status %0d code %h name %h last %0b",
                             $realtime, status, code, name, last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    bit          quiet_span;      // set: neither side idles
    int unsigned stalled_cycles;
    deque_shadow shadow;

    // Small pool so that pushes repeat codes and modify finds first matches
    logic signed [dqku_pkg::DATA_W-1:0] code_pool [6] =
        '{32'sd7, -32'sd7, 32'sd1000, 32'sh0001_0000, -32'sd1, 32'sd0};
    logic signed [dqku_pkg::DATA_W-1:0] code_edges [4] =
        '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 32'sd1};

    dqku_cmd_if cmd_ch();
    dqku_res_if res_ch();

    deque_with_key_update u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Receiver: back-pressure drawn afresh at every falling edge.
    always @(negedge clk)
        res_ch.ready <= quiet_span || ($urandom_range(99) >= STALL_PCT);

    // Result words are taken at the rising edge and checked at once.
    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            shadow.check_word(res_ch.status, res_ch.out_code, res_ch.out_name,
                              res_ch.last);

    // Watchdog: any accepted word on either channel resets the count.
    always @(posedge clk)
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stalled_cycles <= 0;
            else if (stalled_cycles < WATCHDOG_LIMIT)
                stalled_cycles <= stalled_cycles + 1;
            else
            begin
                $display("%0t: no word moved for %0d cycles, %0d result words pending",
                         $realtime, WATCHDOG_LIMIT, shadow.pending_words.size());
                $display("tb_deque_with_key_update NOT OK");
                $finish;
            end
        end

    // ------------------------------------------------------------------
    // Command driver. Idle gaps are drawn per cycle; the word changes only
    // at falling edges and is noted in the shadow once the edge takes it.
    // ------------------------------------------------------------------
    task automatic send_cmd(logic [2:0] act,
                            logic signed [dqku_pkg::DATA_W-1:0] icode,
                            logic [dqku_pkg::DATA_W-1:0] iname,
                            logic signed [dqku_pkg::DATA_W-1:0] ncode,
                            logic [dqku_pkg::DATA_W-1:0] nname);
        @(negedge clk);
        while (!quiet_span && $urandom_range(99) < STALL_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.action    <= act;
        cmd_ch.item_code <= icode;
        cmd_ch.item_name <= iname;
        cmd_ch.new_code  <= ncode;
        cmd_ch.new_name  <= nname;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        shadow.note_command(act, icode, iname, ncode, nname);
    endtask

    function automatic logic signed [dqku_pkg::DATA_W-1:0] pick_code();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return code_pool[$urandom_range(5)];
        if (r < 50)
            return code_edges[$urandom_range(3)];
        return $urandom;
    endfunction

    // Modify searches mostly for a code that is held now, so hits dominate.
    function automatic logic signed [dqku_pkg::DATA_W-1:0] pick_search_code();
        if (shadow.fill > 0 && $urandom_range(99) < 60)
            return shadow.codes[shadow.slot($urandom_range(shadow.fill - 1))];
        return pick_code();
    endfunction

    function automatic logic [2:0] pick_action(mix_mode_t mode, int unsigned r);
        int unsigned         cut [6];
        dqku_pkg::action_t   order [6];
        order = '{dqku_pkg::ACT_PUSH_HEAD, dqku_pkg::ACT_POP_HEAD, dqku_pkg::ACT_POP_TAIL,
                  dqku_pkg::ACT_LIST_HEAD, dqku_pkg::ACT_LIST_TAIL, dqku_pkg::ACT_MODIFY};
        case (mode)
            MODE_FILL:  cut = '{68, 73, 78, 83, 88, 98};
            MODE_DRAIN: cut = '{15, 42, 69, 77, 85, 98};
            default:    cut = '{35, 48, 61, 70, 79, 98};
        endcase
        for (int k = 0; k < 6; k++)
            if (r < cut[k])
                return order[k];
        return r[0] ? ACT_SPARE_6 : ACT_SPARE_7;
    endfunction

    // Directed cases: empty store, unused codes, field extremes and a duplicated code.
    task automatic run_directed();
        // actions on an empty store, then the unused codes
        send_cmd(dqku_pkg::ACT_POP_HEAD,  32'sd5, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_POP_TAIL,  32'sd5, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_LIST_HEAD, 32'sd0, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_LIST_TAIL, 32'sd0, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_MODIFY,    32'sd0, 32'h0, 32'sd1, 32'h1);
        send_cmd(ACT_SPARE_6,   32'sh7fff_ffff, 32'hffff_ffff, 32'sh8000_0000, 32'h0);
        send_cmd(ACT_SPARE_7,   32'sh8000_0000, 32'h0, 32'sh7fff_ffff, 32'hffff_ffff);
        // pushes at the code and tag extremes; max code held twice
        send_cmd(dqku_pkg::ACT_PUSH_HEAD, 32'sh8000_0000, 32'h0000_0000, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_PUSH_HEAD, 32'sh7fff_ffff, 32'hffff_ffff, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_PUSH_HEAD, 32'sd0,         32'ha5a5_a5a5, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_PUSH_HEAD, 32'sh7fff_ffff, 32'h1234_5678, 32'sd0, 32'h0);
        send_cmd(ACT_SPARE_6,   32'sd0, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_LIST_HEAD, 32'sd0, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_LIST_TAIL, 32'sd0, 32'h0, 32'sd0, 32'h0);
        // first match from the head, then the second copy, then a miss
        send_cmd(dqku_pkg::ACT_MODIFY, 32'sh7fff_ffff, 32'h0, 32'sh8000_0000, 32'hffff_ffff);
        send_cmd(dqku_pkg::ACT_MODIFY, 32'sh7fff_ffff, 32'h0, -32'sd1, 32'h0000_0000);
        send_cmd(dqku_pkg::ACT_MODIFY, 32'sh1357_9bdf, 32'h0, 32'sd1, 32'h1);
        send_cmd(dqku_pkg::ACT_POP_TAIL,  32'sd0, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_POP_HEAD,  32'sd0, 32'h0, 32'sd0, 32'h0);
        send_cmd(dqku_pkg::ACT_LIST_HEAD, 32'sd0, 32'h0, 32'sd0, 32'h0);
    endtask

    // Random part in phases: fill phases push the store to full and beyond,
    // drain phases run it down to empty, mixed phases sit in between.
    task automatic run_random(int unsigned count);
        int unsigned done;
        int unsigned phase_left;
        mix_mode_t   mode;
        logic [2:0]  act;
        done       = 0;
        phase_left = 35;
        mode       = MODE_FILL;
        while (done < count)
        begin
            if (phase_left == 0)
            begin
                mode       = mix_mode_t'($urandom_range(2));
                phase_left = $urandom_range(20, 45);
            end
            quiet_span = (done >= 150 && done < 260);
            act        = pick_action(mode, $urandom_range(99));
            if (act == dqku_pkg::ACT_MODIFY)
                send_cmd(act, pick_search_code(), $urandom, pick_code(), $urandom);
            else
                send_cmd(act, pick_code(), $urandom, pick_code(), $urandom);
            if (act <= dqku_pkg::ACT_MODIFY)
            begin
                done++;
                phase_left--;
            end
        end
        quiet_span = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        shadow           = new();
        quiet_span       = 1'b0;
        stalled_cycles   = 0;
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.action    = dqku_pkg::ACT_PUSH_HEAD;
        cmd_ch.item_code = '0;
        cmd_ch.item_name = '0;
        cmd_ch.new_code  = '0;
        cmd_ch.new_name  = '0;
        res_ch.ready     = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(RANDOM_CMDS);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;

        // all predicted words back, then a quiet spell to catch strays
        while (shadow.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d command words (%0d unused codes), %0d result words, %0d bad",
                 shadow.commands, shadow.ignored, shadow.words_seen, shadow.mismatches);
        $display("run: %0d full rejects, %0d empty-store actions, modify %0d hit / %0d miss",
                 shadow.full_rejects, shadow.empty_hits, shadow.modify_hits,
                 shadow.modify_misses);
        $display("run: longest list %0d words", shadow.longest_list);
        if (shadow.mismatches == 0)
            $display("tb_deque_with_key_update OK");
        else
            $display("tb_deque_with_key_update NOT OK");
        $finish;
    end

endmodule
